@@ rtl/isn_pkg.sv @@
`timescale 1ns / 1ps

package isn_pkg;

   localparam int unsigned CapWidth    = 7;
   localparam int unsigned CharWidth   = 7;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned MaxResults  = 3;
   localparam int unsigned ResultIdxW  = 2;

   localparam logic [CapWidth-1:0]  CAP_RESET   = 7'd48;
   localparam logic [ByteWidth-1:0] BYTE_LEAD   = 8'hC3;
   localparam logic [CharWidth-1:0] CHAR_DASH   = 7'h2D;
   localparam logic [CharWidth-1:0] CHAR_S      = 7'h73;
   localparam logic [CharWidth-1:0] CHAR_NONE   = 7'h00;

   typedef enum logic [1:0] {
      KIND_SEP,
      KIND_CHAR,
      KIND_PAIR,
      KIND_LEAD
   } kind_type;

   typedef struct packed {
      logic [CharWidth-1:0] out_char;
      logic                 char_valid;
      logic                 last;
   } result_type;

   typedef struct packed {
      logic                awaiting_continuation;
      logic [CapWidth-1:0] emitted_count;
      logic                dash_pending;
      logic                length_reached;
   } state_type;

   typedef struct packed {
      kind_type             kind;
      logic [CharWidth-1:0] letter;
   } fold_type;

   function automatic fold_type fold_latin(input logic [ByteWidth-1:0] b);
      logic [ByteWidth-1:0] c;
      fold_type             f;
      c        = b;
      f.kind   = KIND_SEP;
      f.letter = CHAR_NONE;
      if (b == 8'hBF) begin
         f.kind   = KIND_CHAR;
         f.letter = 7'h79;
      end else begin
         if (b >= 8'hA0 && b <= 8'hBE) begin
            c = b - 8'h20;
         end
         if (c >= 8'h80 && c <= 8'h85) begin
            f.kind = KIND_CHAR; f.letter = 7'h61;
         end else if (c == 8'h87) begin
            f.kind = KIND_CHAR; f.letter = 7'h63;
         end else if (c >= 8'h88 && c <= 8'h8B) begin
            f.kind = KIND_CHAR; f.letter = 7'h65;
         end else if (c >= 8'h8C && c <= 8'h8F) begin
            f.kind = KIND_CHAR; f.letter = 7'h69;
         end else if (c == 8'h91) begin
            f.kind = KIND_CHAR; f.letter = 7'h6E;
         end else if (c >= 8'h92 && c <= 8'h96) begin
            f.kind = KIND_CHAR; f.letter = 7'h6F;
         end else if (c >= 8'h99 && c <= 8'h9C) begin
            f.kind = KIND_CHAR; f.letter = 7'h75;
         end else if (c == 8'h9D) begin
            f.kind = KIND_CHAR; f.letter = 7'h79;
         end else if (c == 8'h9F) begin
            f.kind = KIND_PAIR; f.letter = CHAR_S;
         end
      end
      return f;
   endfunction

endpackage

@@ rtl/isn_if.sv @@
`timescale 1ns / 1ps

interface isn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface isn_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       char_valid;
   logic       last;

   modport source (output valid, output out_char, output char_valid, output last,
                   input ready);
   modport sink   (input valid, input out_char, input char_valid, input last,
                   output ready);
endinterface

@@ rtl/isn_step.sv @@
`timescale 1ns / 1ps

module isn_step (
   input  logic [7:0]                         in_byte,
   input  logic                               end_of_string,
   input  logic [isn_pkg::CapWidth-1:0]       max_length,
   input  isn_pkg::state_type                 state,
   output isn_pkg::state_type                 state_next,
   output isn_pkg::result_type                results [isn_pkg::MaxResults],
   output logic [isn_pkg::ResultIdxW-1:0]     result_count
);
   import isn_pkg::*;

   fold_type            fold;
   kind_type            kind;
   logic [CharWidth-1:0] letter;
   logic [CapWidth-1:0] count;
   logic                dash;
   logic [ResultIdxW-1:0] n;

   always_comb begin
      fold = fold_latin(in_byte);
      kind   = KIND_SEP;
      letter = CHAR_NONE;
      if (state.awaiting_continuation) begin
         kind   = fold.kind;
         letter = fold.letter;
      end else if (in_byte >= 8'h41 && in_byte <= 8'h5A) begin
         kind   = KIND_CHAR;
         letter = 7'(in_byte + 8'h20);
      end else if ((in_byte >= 8'h61 && in_byte <= 8'h7A) ||
                   (in_byte >= 8'h30 && in_byte <= 8'h39)) begin
         kind   = KIND_CHAR;
         letter = in_byte[6:0];
      end else if (in_byte == BYTE_LEAD && !end_of_string) begin
         kind   = KIND_LEAD;
      end
   end

   always_comb begin
      state_next = state;
      count      = state.emitted_count;
      dash       = state.dash_pending;
      n          = '0;
      for (int i = 0; i < MaxResults; i++) begin
         results[i] = '{out_char: CHAR_NONE, char_valid: 1'b0, last: 1'b0};
      end
      if (!state.length_reached) begin
         state_next.awaiting_continuation = (kind == KIND_LEAD);
         case (kind)
            KIND_CHAR, KIND_PAIR: begin
               if (count < max_length) begin
                  if (dash) begin
                     results[n] = '{out_char: CHAR_DASH, char_valid: 1'b1, last: 1'b0};
                     n = n + 2'd1;
                     dash = 1'b0;
                  end
                  results[n] = '{out_char: letter, char_valid: 1'b1, last: 1'b0};
                  n = n + 2'd1;
                  count = count + 7'd1;
                  if (kind == KIND_PAIR && count < max_length) begin
                     results[n] = '{out_char: letter, char_valid: 1'b1, last: 1'b0};
                     n = n + 2'd1;
                     count = count + 7'd1;
                  end
               end
            end
            KIND_SEP: begin
               if (!dash && count != '0 && count < max_length) begin
                  dash  = 1'b1;
                  count = count + 7'd1;
               end
            end
            default: begin
            end
         endcase
         state_next.emitted_count  = count;
         state_next.dash_pending   = dash;
         state_next.length_reached = (count >= max_length);
      end
      if (end_of_string) begin
         if (n == '0) begin
            n = 2'd1;
         end
         results[n - 2'd1].last = 1'b1;
         state_next = '{awaiting_continuation: 1'b0, emitted_count: '0,
                        dash_pending: 1'b0, length_reached: 1'b0};
      end
      result_count = n;
   end

endmodule

@@ rtl/identifier_slug_normalizer.sv @@
`timescale 1ns / 1ps

// Turns a UTF-8 string, one byte per req transaction, into a lowercase slug of a-z,
// 0-9 and dash on rsp, one character per transaction; the result with last set
// closes the string, and an end byte that yields no character (so any string with
// no characters) yields one bare end marker (char_valid low). csr_write_data sets
// the length cap (reset 48); the user must write it while the block is idle, as
// the block does not enforce this. A byte is taken every cycle while rsp is ready
// and each byte yields at most one result; a byte with two or three results (a dash
// before a letter, or sharp s) holds req as they leave the single rsp slot, one per cycle.
module identifier_slug_normalizer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [isn_pkg::CapWidth-1:0] csr_write_data,
   isn_req_if.sink                      req_chan,
   isn_rsp_if.source                    rsp_chan
);
   import isn_pkg::*;

   logic [CapWidth-1:0]   max_length_ff;
   state_type             state_ff, state_in;
   result_type            slot_ff [MaxResults];
   result_type            slot_in [MaxResults];
   logic [ResultIdxW-1:0] rem_ff, pos_ff, count_in;
   logic                  req_take, rsp_take;

   isn_step u_step (
      .in_byte       (req_chan.in_byte),
      .end_of_string (req_chan.end_of_string),
      .max_length    (max_length_ff),
      .state         (state_ff),
      .state_next    (state_in),
      .results       (slot_in),
      .result_count  (count_in)
   );

   assign rsp_chan.valid      = (rem_ff != '0);
   assign rsp_chan.out_char   = slot_ff[pos_ff].out_char;
   assign rsp_chan.char_valid = slot_ff[pos_ff].char_valid;
   assign rsp_chan.last       = slot_ff[pos_ff].last;

   assign req_chan.ready = (rem_ff == '0) || (rem_ff == 2'd1 && rsp_chan.ready);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= CAP_RESET;
         state_ff      <= '0;
         rem_ff        <= '0;
         pos_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            max_length_ff <= csr_write_data;
         end
         if (req_take) begin
            state_ff <= state_in;
            rem_ff   <= count_in;
            pos_ff   <= '0;
         end else if (rsp_take) begin
            rem_ff <= rem_ff - 2'd1;
            pos_ff <= pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         slot_ff <= slot_in;
      end
   end

`ifndef SYNTHESIS
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, rem_ff} + {1'b0, pos_ff}) <= 3'(MaxResults))
      else $error("result slot pointer beyond the stored results");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_take && rsp_chan.valid) |-> (rem_ff == 2'd1 && rsp_chan.ready))
      else $error("new transaction taken over undelivered results");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.char_valid) |-> rsp_chan.last)
      else $error("bare end marker without last");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_chan.end_of_string) |=> (state_ff == '0))
      else $error("string state not cleared after end of string");
`endif

endmodule
